// ===== sv/pgb_pkg.sv =====
// Shared types and constants of the palette Gaussian blur block.
`default_nettype none

package pgb_pkg;

   // Palette geometry and color layout
   localparam int PAL_DEPTH = 1024;
   localparam int PAL_AW    = 10;
   localparam int COLOR_W   = 24;
   localparam int CHAN_W    = 8;
   localparam int NUM_CHAN  = 3;
   localparam int COL_ROWS  = 3;
   localparam int WIN_SIZE  = 9;

   // Kernel sum: nine 8-bit taps weighted up to 4, total weight 16
   localparam int SUM_W     = 12;
   localparam int SUM_SHIFT = 4;

   // Operation codes carried by the request word
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   // 1-2-1 by 1-2-1 weights as left shifts, indexed 3*column + row
   localparam logic [1:0] WEIGHT_SHIFT [WIN_SIZE] = '{
      2'd0, 2'd1, 2'd0,
      2'd1, 2'd2, 2'd1,
      2'd0, 2'd1, 2'd0
   };

   typedef logic [COLOR_W-1:0] color_type;
   typedef logic [PAL_AW-1:0]  pal_addr_type;
   typedef logic [CHAN_W-1:0]  chan_type;

   // 3x3 window of RGB colors, entry 3*column + row, column 0 oldest, row 0 top
   typedef color_type [WIN_SIZE-1:0] window_type;

   // Blurred pixel handed from the kernel to the result register
   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } pixel_type;

endpackage

`default_nettype wire

// ===== sv/pgb_req_if.sv =====
// Request channel: palette writes and pixel columns.
`default_nettype none

interface pgb_req_if;
   logic                 valid;
   logic                 ready;
   logic                 operation;
   pgb_pkg::pal_addr_type palette_address;
   pgb_pkg::color_type   palette_color;
   pgb_pkg::pal_addr_type index_top;
   pgb_pkg::pal_addr_type index_middle;
   pgb_pkg::pal_addr_type index_bottom;
   logic                 row_start;

   modport source (
      output valid, operation, palette_address, palette_color,
             index_top, index_middle, index_bottom, row_start,
      input  ready
   );

   modport sink (
      input  valid, operation, palette_address, palette_color,
             index_top, index_middle, index_bottom, row_start,
      output ready
   );
endinterface

`default_nettype wire

// ===== sv/pgb_rsp_if.sv =====
// Response channel: blurred RGB pixels.
`default_nettype none

interface pgb_rsp_if;
   logic              valid;
   logic              ready;
   pgb_pkg::chan_type red;
   pgb_pkg::chan_type green;
   pgb_pkg::chan_type blue;

   modport source (
      output valid, red, green, blue,
      input  ready
   );

   modport sink (
      input  valid, red, green, blue,
      output ready
   );
endinterface

`default_nettype wire

// ===== sv/palette_gaussian_blur_3x3.sv =====
// Top level of the palette-indexed 3x3 Gaussian blur.
//
// Request words arrive on req_bus. A write word (operation = 0) stores
// palette_color at palette_address and gives no response. A pixel word
// (operation = 1) carries one column of three palette indices; each index
// above MAX_ITER clamps to entry min(MAX_ITER, 1023). The three colors are
// read from three copies of the palette in the accept cycle and shifted
// into a two-column window held in flops; row_start restarts the column
// count, so the first two columns of each row give no response.
// Every later column gives one blurred RGB word on rsp_bus.
// Throughput: one request word per clock while rsp_bus is not stalled, set
// by the one read port per palette copy. A response passes the palette
// read register, loaded at the edge that accepts its column, and then the
// result register.
// When rsp_bus stalls, the result register holds and the read stage keeps
// accepting until it holds a column that must produce a response; columns
// that produce none still drain. Reset clears the window, the column count
// and all valid flags and holds req_bus ready low; palette contents are
// undefined until written.
`default_nettype none

module palette_gaussian_blur_3x3 #(
   parameter int MAX_ITER = 1023
) (
   input wire logic clock,
   input wire logic reset,
   pgb_req_if.sink   req_bus,
   pgb_rsp_if.source rsp_bus
);

   // Highest palette address an index may reach
   localparam int CLAMP_INT = (MAX_ITER > pgb_pkg::PAL_DEPTH - 1) ?
                              pgb_pkg::PAL_DEPTH - 1 : MAX_ITER;
   localparam pgb_pkg::pal_addr_type CLAMP_ADDR = pgb_pkg::PAL_AW'(CLAMP_INT);

   logic                  req_accept;
   logic                  pal_wr_en;
   logic                  pal_rd_en;
   pgb_pkg::pal_addr_type rd_index [pgb_pkg::COL_ROWS];
   pgb_pkg::pal_addr_type rd_addr  [pgb_pkg::COL_ROWS];
   pgb_pkg::color_type    rd_color [pgb_pkg::COL_ROWS];

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_row_ff, s1_row_in;
   logic [1:0]            seen_ff, seen_in;
   pgb_pkg::color_type    hist_ff [6];
   pgb_pkg::color_type    hist_in [6];

   logic                  s1_seen_cur;
   logic [1:0]            s1_seen;
   logic                  s1_produce;
   logic                  s1_retire;
   logic                  rsp_load;
   pgb_pkg::window_type   win;
   pgb_pkg::pixel_type    pixel;

   logic                  rsp_valid_ff, rsp_valid_in;
   pgb_pkg::pixel_type    rsp_pix_ff, rsp_pix_in;

   // Accept decode
   assign req_accept = req_bus.valid && req_bus.ready;
   assign pal_wr_en  = req_accept && (req_bus.operation == pgb_pkg::OP_WRITE);
   assign pal_rd_en  = req_accept && (req_bus.operation == pgb_pkg::OP_PIXEL);

   assign rd_index[0] = req_bus.index_top;
   assign rd_index[1] = req_bus.index_middle;
   assign rd_index[2] = req_bus.index_bottom;

   // Clamp indices and read one palette copy per row
   for (genvar r = 0; r < pgb_pkg::COL_ROWS; r++) begin : g_pal
      assign rd_addr[r] = (rd_index[r] > CLAMP_ADDR) ? CLAMP_ADDR : rd_index[r];

      pgb_ram #(
         .WIDTH (pgb_pkg::COLOR_W),
         .DEPTH (pgb_pkg::PAL_DEPTH)
      ) u_pal (
         .clock   (clock),
         .wr_en   (pal_wr_en),
         .wr_addr (req_bus.palette_address),
         .wr_data (req_bus.palette_color),
         .rd_en   (pal_rd_en),
         .rd_addr (rd_addr[r]),
         .rd_data (rd_color[r])
      );
   end

   // Read stage: decide whether the column produces a pixel and when it leaves
   assign s1_seen_cur = s1_row_ff ? 1'b0 : 1'b1;
   assign s1_seen     = s1_seen_cur ? seen_ff : 2'd0;
   assign s1_produce  = (s1_seen == 2'd2);
   assign s1_retire   = s1_valid_ff && (!s1_produce || !rsp_valid_ff || rsp_bus.ready);
   assign rsp_load    = s1_retire && s1_produce;

   assign req_bus.ready = !reset && (!s1_valid_ff || s1_retire);

   // Assemble the window: two stored columns plus the fresh one
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         win[i] = hist_ff[i];
      end
      for (int r = 0; r < pgb_pkg::COL_ROWS; r++) begin
         win[6 + r] = rd_color[r];
      end
   end

   pgb_kernel u_kernel (
      .win   (win),
      .pixel (pixel)
   );

   // Next state of the read stage, window and column count
   always_comb begin
      s1_valid_in = pal_rd_en ? 1'b1 : (s1_retire ? 1'b0 : s1_valid_ff);
      s1_row_in   = pal_rd_en ? req_bus.row_start : s1_row_ff;
      seen_in     = seen_ff;
      for (int i = 0; i < 6; i++) begin
         hist_in[i] = hist_ff[i];
      end
      if (s1_retire) begin
         seen_in = s1_produce ? 2'd2 : s1_seen + 2'd1;
         for (int i = 0; i < 6; i++) begin
            hist_in[i] = win[i + 3];
         end
      end
   end

   // Result register: load on a producing column, drop when taken
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_bus.ready);
   assign rsp_pix_in   = rsp_load ? pixel : rsp_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_row_ff    <= 1'b0;
         seen_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s1_row_ff    <= s1_row_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 6; i++) begin
            hist_ff[i] <= hist_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_pix_ff <= rsp_pix_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.red   = rsp_pix_ff.red;
   assign rsp_bus.green = rsp_pix_ff.green;
   assign rsp_bus.blue  = rsp_pix_ff.blue;

   // Column count saturates at two
   a_seen_sat: assert property (@(posedge clock) disable iff (reset)
      seen_ff != 2'd3)
      else $error("column count out of range");

   // A row-start column never loads a response
   a_row_silent: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_row_ff && rsp_bus.ready) |=> !rsp_valid_ff)
      else $error("response after row start column");

   // A producing column waits while the result register is stalled
   a_hold_produce: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_produce && rsp_valid_ff && !rsp_bus.ready) |=>
      (s1_valid_ff && rsp_valid_ff))
      else $error("producing column lost during stall");

endmodule

`default_nettype wire

// ===== sv/pgb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pgb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port: hold the last data while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/pgb_kernel.sv =====
// 3x3 Gaussian kernel: weighted sum of the window per channel, scaled by 1/16.
`default_nettype none

module pgb_kernel (
   input  wire pgb_pkg::window_type win,
   output pgb_pkg::pixel_type       pixel
);

   logic [pgb_pkg::SUM_W-1:0] sum [pgb_pkg::NUM_CHAN];

   // Accumulate the weighted taps of each channel; channel 0 is blue
   always_comb begin
      for (int c = 0; c < pgb_pkg::NUM_CHAN; c++) begin
         sum[c] = '0;
         for (int i = 0; i < pgb_pkg::WIN_SIZE; i++) begin
            sum[c] = sum[c] + (pgb_pkg::SUM_W'(win[i][pgb_pkg::CHAN_W*c +: pgb_pkg::CHAN_W])
                               << pgb_pkg::WEIGHT_SHIFT[i]);
         end
      end
   end

   // Drop the four fraction bits
   assign pixel.blue  = sum[0][pgb_pkg::SUM_W-1:pgb_pkg::SUM_SHIFT];
   assign pixel.green = sum[1][pgb_pkg::SUM_W-1:pgb_pkg::SUM_SHIFT];
   assign pixel.red   = sum[2][pgb_pkg::SUM_W-1:pgb_pkg::SUM_SHIFT];

endmodule

`default_nettype wire
